// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== sv/cbb_pkg.sv =====
`timescale 1ns / 1ps
package cbb_pkg;

  localparam int unsigned CoordWidth = 24;
  localparam int unsigned AW    = CoordWidth + 3;
  localparam int unsigned HW    = CoordWidth + 2;
  localparam int unsigned CW    = CoordWidth + 1;
  localparam int unsigned NumW  = CoordWidth + 4;
  localparam int unsigned DenW  = CoordWidth + 3;
  localparam int unsigned DW    = 2 * CoordWidth + 5;
  localparam int unsigned RadW  = DW - 1;
  localparam int unsigned RootW = CoordWidth + 2;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p3_x;
    coord_t p3_y;
  } in_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } out_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] v0;
    logic signed [CW-1:0]         c;
    logic signed [HW-1:0]         h;
    logic signed [AW-1:0]         a;
  } coef_t;

endpackage

// ===== sv/cbb_div.sv =====
`timescale 1ns / 1ps
module cbb_div #(
  parameter int unsigned FracBits = 16,
  parameter int unsigned Width    = 27
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [Width-1:0]    num_i,
  input  logic [Width-1:0]    den_i,
  output logic [FracBits-1:0] q_o
);

  logic [Width-1:0]    rem_q [FracBits];
  logic [Width-1:0]    den_q [FracBits];
  logic [FracBits-1:0] q_q   [FracBits];

  for (genvar k = 0; k < FracBits; k++) begin : g_stage
    logic [Width-1:0]    rem_in;
    logic [Width-1:0]    den_in;
    logic [FracBits-1:0] q_in;
    logic [Width:0]      r2;
    logic                ge;
    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign q_in   = q_q[k-1];
    end
    assign r2 = {rem_in, 1'b0};
    assign ge = r2 >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? Width'(r2 - {1'b0, den_in}) : Width'(r2);
        den_q[k] <= den_in;
        q_q[k]   <= {q_in[FracBits-2:0], ge};
      end
    end
  end

  assign q_o = q_q[FracBits-1];

endmodule

// ===== sv/cbb_root.sv =====
`timescale 1ns / 1ps
module cbb_root #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  cbb_pkg::coord_t     v0_i,
  input  cbb_pkg::coord_t     v1_i,
  input  cbb_pkg::coord_t     v2_i,
  input  cbb_pkg::coord_t     v3_i,
  output cbb_pkg::coef_t      coef_o,
  output logic [FracBits-1:0] t0_o,
  output logic [FracBits-1:0] t1_o
);
  import cbb_pkg::*;

  typedef struct packed {
    coef_t           coef;
    logic            neg;
    logic [RadW-1:0] rad;
    logic [RootW-1:0] r;
    logic [RadW:0]   sq;
  } sqrt_t;

  typedef struct packed {
    logic [DenW-1:0] num;
    logic [DenW-1:0] den;
  } cand_t;

  function automatic cand_t norm(logic signed [NumW-1:0] n, logic signed [NumW-1:0] d,
                                 logic ok);
    logic signed [NumW-1:0] nn;
    logic signed [NumW-1:0] dd;
    cand_t res;
    nn = (d < 0) ? -n : n;
    dd = (d < 0) ? -d : d;
    if (ok && nn > 0 && nn < dd) begin
      res.num = nn[DenW-1:0];
      res.den = dd[DenW-1:0];
    end else begin
      res.num = '0;
      res.den = DenW'(1);
    end
    return res;
  endfunction

  // coefficients
  logic signed [AW-1:0] d12;
  coef_t coef_d, coef1_q, coef2_q;
  always_comb begin
    d12       = AW'(v1_i) - AW'(v2_i);
    coef_d.v0 = v0_i;
    coef_d.a  = AW'(v3_i) - AW'(v0_i) + d12 + (d12 <<< 1);
    coef_d.h  = HW'(v0_i) - (HW'(v1_i) <<< 1) + HW'(v2_i);
    coef_d.c  = CW'(v1_i) - CW'(v0_i);
  end

  // discriminant products
  logic signed [2*HW-1:0]   hh_d, hh_q;
  logic signed [AW+CW-1:0]  ac_d, ac_q;
  logic signed [DW-1:0]     disc;
  assign hh_d = coef1_q.h * coef1_q.h;
  assign ac_d = coef1_q.a * coef1_q.c;
  assign disc = DW'(hh_q) - DW'(ac_q);

  sqrt_t st_q [RootW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef1_q        <= coef_d;
      coef2_q        <= coef1_q;
      hh_q           <= hh_d;
      ac_q           <= ac_d;
      st_q[0].coef   <= coef2_q;
      st_q[0].neg    <= disc < 0;
      st_q[0].rad    <= (disc < 0) ? '0 : disc[RadW-1:0];
      st_q[0].r      <= '0;
      st_q[0].sq     <= '0;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    localparam int unsigned B = RootW - 1 - k;
    logic [RadW:0] trial;
    logic          take;
    assign trial = st_q[k].sq + ((RadW+1)'(st_q[k].r) << (B + 1))
                 + ((RadW+1)'(1) << (2 * B));
    assign take  = trial <= {1'b0, st_q[k].rad};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1].coef <= st_q[k].coef;
        st_q[k+1].neg  <= st_q[k].neg;
        st_q[k+1].rad  <= st_q[k].rad;
        st_q[k+1].r    <= take ? (st_q[k].r | (RootW'(1) << B)) : st_q[k].r;
        st_q[k+1].sq   <= take ? trial : st_q[k].sq;
      end
    end
  end

  // root candidates
  sqrt_t                  sf;
  logic signed [NumW-1:0] rs, hn;
  cand_t                  c0_d, c1_d, c0_q, c1_q;
  coef_t                  coef4_q;
  always_comb begin
    sf = st_q[RootW];
    rs = NumW'($signed({1'b0, sf.r}));
    hn = -NumW'(sf.coef.h);
    if (sf.coef.a == '0) begin
      c0_d = norm(-NumW'(sf.coef.c), NumW'(sf.coef.h) <<< 1, sf.coef.h != '0);
      c1_d = norm('0, NumW'(1), 1'b0);
    end else begin
      c0_d = norm(hn + rs, NumW'(sf.coef.a), !sf.neg);
      c1_d = norm(hn - rs, NumW'(sf.coef.a), !sf.neg);
    end
  end

  coef_t coef_dl_q [FracBits];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q    <= c0_d;
      c1_q    <= c1_d;
      coef4_q <= sf.coef;
      coef_dl_q[0] <= coef4_q;
      for (int i = 1; i < FracBits; i++) coef_dl_q[i] <= coef_dl_q[i-1];
    end
  end

  cbb_div #(.FracBits(FracBits), .Width(DenW)) u_div0 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (c0_q.num),
    .den_i (c0_q.den),
    .q_o   (t0_o)
  );

  cbb_div #(.FracBits(FracBits), .Width(DenW)) u_div1 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (c1_q.num),
    .den_i (c1_q.den),
    .q_o   (t1_o)
  );

  assign coef_o = coef_dl_q[FracBits-1];

endmodule

// ===== sv/cbb_eval.sv =====
`timescale 1ns / 1ps
module cbb_eval #(
  parameter int unsigned FracBits = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [FracBits-1:0] t_i,
  input  cbb_pkg::coef_t      coef_i,
  output cbb_pkg::coord_t     p_o
);
  import cbb_pkg::*;

  localparam int unsigned F   = FracBits;
  localparam int unsigned HTW = HW + 2 * F + 1;
  localparam int unsigned SW  = CoordWidth + 3 * F + 6;

  logic [F-1:0]          t1_q;
  logic [2*F-1:0]        t2_q;
  coef_t                 coef1_q, coef2_q, coef3_q;
  logic signed [CW+F:0]  ct_d, ct2_q, ct3_q, ct4_q;
  logic signed [HW+F:0]  ph0_d, ph1_d, ph0_q, ph1_q;
  logic [2*F-1:0]        m0_d, m1_d, m0_q, m1_q;
  logic [3*F-1:0]        t3_d, t3_q;
  logic signed [HTW-1:0] ht_d, ht3_q, ht4_q;
  logic signed [AW+F:0]  pa0_d, pa1_d, pa2_d, pa0_q, pa1_q, pa2_q;
  logic signed [CoordWidth-1:0] v0_q;
  logic signed [SW-1:0]  at3_d, oth_d, at3_q, oth_q, sum;
  coord_t                p_q;

  // power form scaled by 2^(3F): v0 + 3ct + 3ht^2 + at^3
  assign ct_d  = coef1_q.c * $signed({1'b0, t1_q});
  assign ph0_d = coef1_q.h * $signed({1'b0, t2_q[F-1:0]});
  assign ph1_d = coef1_q.h * $signed({1'b0, t2_q[2*F-1:F]});
  assign m0_d  = t2_q[F-1:0] * t1_q;
  assign m1_d  = t2_q[2*F-1:F] * t1_q;
  assign t3_d  = (3*F)'(m0_q) + ((3*F)'(m1_q) << F);
  assign ht_d  = HTW'(ph0_q) + (HTW'(ph1_q) <<< F);
  assign pa0_d = coef3_q.a * $signed({1'b0, t3_q[F-1:0]});
  assign pa1_d = coef3_q.a * $signed({1'b0, t3_q[2*F-1:F]});
  assign pa2_d = coef3_q.a * $signed({1'b0, t3_q[3*F-1:2*F]});
  assign at3_d = SW'(pa0_q) + (SW'(pa1_q) <<< F) + (SW'(pa2_q) <<< (2 * F));
  assign oth_d = (SW'(v0_q) <<< (3 * F))
               + ((SW'(ct4_q) + (SW'(ct4_q) <<< 1)) <<< (2 * F))
               + ((SW'(ht4_q) + (SW'(ht4_q) <<< 1)) <<< F)
               + (SW'(1) <<< (3 * F - 1));
  assign sum   = at3_q + oth_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= t_i;
      t2_q    <= t_i * t_i;
      coef1_q <= coef_i;
      ct2_q   <= ct_d;
      ph0_q   <= ph0_d;
      ph1_q   <= ph1_d;
      m0_q    <= m0_d;
      m1_q    <= m1_d;
      coef2_q <= coef1_q;
      t3_q    <= t3_d;
      ht3_q   <= ht_d;
      ct3_q   <= ct2_q;
      coef3_q <= coef2_q;
      pa0_q   <= pa0_d;
      pa1_q   <= pa1_d;
      pa2_q   <= pa2_d;
      ct4_q   <= ct3_q;
      ht4_q   <= ht3_q;
      v0_q    <= coef3_q.v0;
      at3_q   <= at3_d;
      oth_q   <= oth_d;
      p_q     <= sum[3*F +: CoordWidth];
    end
  end

  assign p_o = p_q;

endmodule

// ===== sv/cubic_bezier_bounding_box_core.sv =====
// the 26-stage square root and the one-bit-per-stage divider make up most of the pipeline
// throughput: one word per cycle; a stalled output holds every stage in place
// reset clears the valid bits only; the datapath registers are not reset
`timescale 1ns / 1ps
module cubic_bezier_bounding_box_core #(
  parameter int unsigned PARAM_FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cbb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cbb_pkg::out_t out_data_o
);
  import cbb_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned RootLat = 4 + RootW + PARAM_FRAC_BITS;
  localparam int unsigned EvalLat = 6;
  localparam int unsigned Lat     = RootLat + EvalLat;

  logic                 en;
  logic [Lat-1:0]       vld_q;
  out_t                 ep_d;
  out_t                 ep_q [Lat];
  out_t                 box_d, out_q;
  logic                 out_valid_q;
  coef_t                coef_x, coef_y;
  logic [PARAM_FRAC_BITS-1:0] tr [4];
  coord_t               px [4];
  coord_t               py [4];

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    ep_d.min_x = (in_data_i.p0_x < in_data_i.p3_x) ? in_data_i.p0_x : in_data_i.p3_x;
    ep_d.max_x = (in_data_i.p0_x < in_data_i.p3_x) ? in_data_i.p3_x : in_data_i.p0_x;
    ep_d.min_y = (in_data_i.p0_y < in_data_i.p3_y) ? in_data_i.p0_y : in_data_i.p3_y;
    ep_d.max_y = (in_data_i.p0_y < in_data_i.p3_y) ? in_data_i.p3_y : in_data_i.p0_y;
  end

  cbb_root #(.FracBits(PARAM_FRAC_BITS)) u_root_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .v0_i   (in_data_i.p0_x),
    .v1_i   (in_data_i.p1_x),
    .v2_i   (in_data_i.p2_x),
    .v3_i   (in_data_i.p3_x),
    .coef_o (coef_x),
    .t0_o   (tr[0]),
    .t1_o   (tr[1])
  );

  cbb_root #(.FracBits(PARAM_FRAC_BITS)) u_root_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .v0_i   (in_data_i.p0_y),
    .v1_i   (in_data_i.p1_y),
    .v2_i   (in_data_i.p2_y),
    .v3_i   (in_data_i.p3_y),
    .coef_o (coef_y),
    .t0_o   (tr[2]),
    .t1_o   (tr[3])
  );

  for (genvar i = 0; i < 4; i++) begin : g_eval
    cbb_eval #(.FracBits(PARAM_FRAC_BITS)) u_eval_x (
      .clk_i  (clk_i),
      .en_i   (en),
      .t_i    (tr[i]),
      .coef_i (coef_x),
      .p_o    (px[i])
    );
    cbb_eval #(.FracBits(PARAM_FRAC_BITS)) u_eval_y (
      .clk_i  (clk_i),
      .en_i   (en),
      .t_i    (tr[i]),
      .coef_i (coef_y),
      .p_o    (py[i])
    );
  end

  // widen the end-point box by the extremum points
  always_comb begin
    box_d = ep_q[Lat-1];
    for (int i = 0; i < 4; i++) begin
      if (px[i] < box_d.min_x) box_d.min_x = px[i];
      if (px[i] > box_d.max_x) box_d.max_x = px[i];
      if (py[i] < box_d.min_y) box_d.min_y = py[i];
      if (py[i] > box_d.max_y) box_d.max_y = py[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Lat-2:0], in_valid_i};
      out_valid_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ep_q[0] <= ep_d;
      for (int i = 1; i < Lat; i++) ep_q[i] <= ep_q[i-1];
      out_q   <= box_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_box_x, out_valid_o, out_data_o.min_x <= out_data_o.max_x, "x box inverted")
  `ASSERT_IMPL(a_box_y, out_valid_o, out_data_o.min_y <= out_data_o.max_y, "y box inverted")
  `ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q), "pipeline moved while stalled")

endmodule
